// ----- sv/mf_pkg.sv -----
// ----------------------------------------------------------------------------
// mf_pkg
// Shared types and codes for the two-dimensional median filter.
// ----------------------------------------------------------------------------
package mf_pkg;

    // Register indexes of the configuration port
    localparam logic CFG_IDX_SIZE   = 1'b0;
    localparam logic CFG_IDX_RADIUS = 1'b1;

    // Per-pixel job flags handed from the front to the back
    typedef struct packed {
        logic clear;      // first pixel of a row: empty the histogram
        logic do_hist;    // enough rows seen: update the histogram
        logic remove;     // drop the oldest column first
        logic emit;       // window complete: search and give a median
        logic row_end;
        logic frame_end;
    } t_job_ctrl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REM_RD,
        BK_REM_WR,
        BK_ADD_RD,
        BK_ADD_WR,
        BK_SRCH,
        BK_OUT
    } t_back_state;

endpackage

// ----- sv/mf_ram.sv -----
// ----------------------------------------------------------------------------
// mf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/mf_queue.sv -----
// ----------------------------------------------------------------------------
// mf_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module mf_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_room,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt < CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < CW'(DEPTH)))
        else $error("job pushed into a full queue");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("job popped from an empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");
endmodule

// ----- sv/mf_front.sv -----
// ----------------------------------------------------------------------------
// mf_front
// Accept pixels, track position, run the line store, and issue column jobs.
// ----------------------------------------------------------------------------
module mf_front #(
    parameter int MAX_SIZE   = 512,
    parameter int MAX_RADIUS = 3,
    parameter int VB         = 8,
    parameter int NW         = 10,
    parameter int SLW        = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_pixel,
    input  logic                            i_restart,
    input  logic [NW-1:0]                   i_size,
    input  logic [3:0]                      i_lanes,
    input  logic [3:0]                      i_side,
    input  logic                            i_q_room,
    output logic                            o_push,
    output mf_pkg::t_job_ctrl               o_ctrl,
    output logic [SLW-1:0]                  o_slot,
    output logic [VB*(2*MAX_RADIUS+1)-1:0]  o_col
);
    import mf_pkg::*;

    localparam int L    = 2 * MAX_RADIUS;
    localparam int LX   = (L > 0) ? L : 1;
    localparam int SMAX = 2 * MAX_RADIUS + 1;
    localparam int AW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [NW-1:0]  r_col, r_row;
    logic [SLW-1:0] r_slot, r_jslot;
    logic           r_busy;
    logic [VB-1:0]  r_pix;
    logic [AW-1:0]  r_addr;
    t_job_ctrl      r_ctrl, n_ctrl;
    logic [VB-1:0]  rd [LX];
    logic           accept, col_last, row_last;

    assign o_ready  = !r_busy && i_q_room;
    assign accept   = i_valid && o_ready;
    assign col_last = (r_col + 1'b1 >= i_size);
    assign row_last = (r_row + 1'b1 >= i_size);

    always_comb begin
        n_ctrl.clear     = (r_col == '0);
        n_ctrl.do_hist   = (r_row >= NW'(i_lanes));
        n_ctrl.remove    = (r_col >= NW'(i_side));
        n_ctrl.emit      = n_ctrl.do_hist && (r_col >= NW'(i_lanes));
        n_ctrl.row_end   = (r_col == i_size - 1'b1);
        n_ctrl.frame_end = n_ctrl.row_end && (r_row == i_size - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
            if (i_restart) begin
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= '0;
            end else if (accept) begin
                if (col_last) begin
                    r_col  <= '0;
                    r_slot <= '0;
                    r_row  <= row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col  <= r_col + 1'b1;
                    r_slot <= (4'(r_slot) == i_side - 1'b1) ? '0 : r_slot + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix   <= i_pixel[VB-1:0];
            r_addr  <= r_col[AW-1:0];
            r_ctrl  <= n_ctrl;
            r_jslot <= r_slot;
        end
    end

    // Line store: one RAM per buffered row, shifted column-wise on write
    for (genvar k = 0; k < L; k++) begin : g_lane
        logic [VB-1:0] wdata;
        if (k + 1 < L) begin : g_mid
            assign wdata = (4'(k) == i_lanes - 1'b1) ? r_pix : rd[k+1];
        end else begin : g_top
            assign wdata = r_pix;
        end
        mf_ram #(.WIDTH(VB), .DEPTH(MAX_SIZE)) u_line (
            .i_clk   (i_clk),
            .i_we    (r_busy && (4'(k) < i_lanes)),
            .i_waddr (r_addr),
            .i_wdata (wdata),
            .i_raddr (r_col[AW-1:0]),
            .o_rdata (rd[k])
        );
    end
    if (L == 0) begin : g_nolane
        assign rd[0] = '0;
    end

    for (genvar k = 0; k < SMAX; k++) begin : g_col
        if (k < L) begin : g_buf
            assign o_col[k*VB +: VB] = (4'(k) < i_lanes) ? rd[k] :
                                       (4'(k) == i_lanes) ? r_pix : '0;
        end else begin : g_new
            assign o_col[k*VB +: VB] = (4'(k) == i_lanes) ? r_pix : '0;
        end
    end

    assign o_push = r_busy;
    assign o_ctrl = r_ctrl;
    assign o_slot = r_jslot;
endmodule

// ----- sv/mf_back.sv -----
// ----------------------------------------------------------------------------
// mf_back
// Column ring, value histogram update and median search.
// ----------------------------------------------------------------------------
module mf_back #(
    parameter int VB   = 8,
    parameter int SMAX = 7,
    parameter int SLW  = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  mf_pkg::t_job_ctrl       i_ctrl,
    input  logic [SLW-1:0]          i_slot,
    input  logic [VB*SMAX-1:0]      i_col,
    output logic                    o_pop,
    input  logic [3:0]              i_side,
    input  logic [5:0]              i_need,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_median,
    output logic                    o_row_end,
    output logic                    o_frame_end
);
    import mf_pkg::*;

    localparam int BINS = 1 << VB;

    t_back_state    r_state, n_state;
    t_job_ctrl      r_ctrl;
    logic [SLW-1:0] r_slot, r_k;
    logic [VB-1:0]  r_colv [SMAX];
    logic [VB-1:0]  r_ring [SMAX][SMAX];
    logic [BINS-1:0] r_valid;
    logic [VB-1:0]  r_saddr, r_chk, r_med;
    logic           r_sv, r_pend;
    logic [6:0]     r_acc;

    logic [VB-1:0]  cur, ram_addr;
    logic [5:0]     rdata, cnt, upd;
    logic           ram_we, last, rem, hit;
    logic [6:0]     sum;

    assign rem  = (r_state == BK_REM_RD) || (r_state == BK_REM_WR);
    assign cur  = rem ? r_ring[r_slot][r_k] : r_colv[r_k];
    assign last = (4'(r_k) == i_side - 1'b1);
    assign cnt  = r_valid[cur] ? rdata : '0;
    assign upd  = rem ? ((cnt != '0) ? cnt - 1'b1 : '0) : cnt + 1'b1;
    assign sum  = r_acc + 7'(r_sv ? rdata : 6'd0);
    assign hit  = (sum >= 7'(i_need)) || (r_chk == '1);
    assign ram_addr = (r_state == BK_SRCH) ? r_saddr : cur;

    mf_ram #(.WIDTH(6), .DEPTH(BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur),
        .i_wdata (upd),
        .i_raddr (ram_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        ram_we  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_ctrl.do_hist) begin
                        n_state = i_ctrl.remove ? BK_REM_RD : BK_ADD_RD;
                    end
                end
            end
            BK_REM_RD: n_state = BK_REM_WR;
            BK_REM_WR: begin
                ram_we  = 1'b1;
                n_state = last ? BK_ADD_RD : BK_REM_RD;
            end
            BK_ADD_RD: n_state = BK_ADD_WR;
            BK_ADD_WR: begin
                ram_we = 1'b1;
                if (last) begin
                    n_state = r_ctrl.emit ? BK_SRCH : BK_IDLE;
                end else begin
                    n_state = BK_ADD_RD;
                end
            end
            BK_SRCH: begin
                if (r_pend && hit) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_ctrl.clear) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[cur] <= 1'b1;
            end
            if (r_state == BK_SRCH) begin
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctrl <= i_ctrl;
            r_slot <= i_slot;
            r_k    <= '0;
            for (int k = 0; k < SMAX; k++) begin
                r_colv[k] <= i_col[k*VB +: VB];
            end
        end else if (ram_we) begin
            r_k <= last ? '0 : r_k + 1'b1;
        end
        // Store the new column once its counts are in
        if (r_state == BK_ADD_WR && last) begin
            for (int k = 0; k < SMAX; k++) begin
                r_ring[r_slot][k] <= r_colv[k];
            end
            r_saddr <= '0;
            r_acc   <= '0;
        end
        if (r_state == BK_SRCH) begin
            r_saddr <= r_saddr + 1'b1;
            r_chk   <= r_saddr;
            r_sv    <= r_valid[r_saddr];
            if (r_pend) begin
                r_acc <= sum;
                if (hit) begin
                    r_med <= r_chk;
                end
            end
        end
    end

    assign o_valid     = (r_state == BK_OUT);
    assign o_median    = 8'(r_med);
    assign o_row_end   = r_ctrl.row_end;
    assign o_frame_end = r_ctrl.frame_end;
endmodule

// ----- sv/median_filter_2d.sv -----
// ----------------------------------------------------------------------------
// median_filter_2d
// Two-dimensional median filter over a square raster image, histogram method.
// ----------------------------------------------------------------------------
// Front: per pixel a line store read, then the shifted write and job push; the
//   next pixel is taken after that push, while the queue has room.
// Back: histogram read-modify-write over the dropped column, if any, and the new
//   column (side = 2*radius+1); full window: bin scan to the median, output.
// Reset (synchronous, active low) empties the queue, clears the histogram
//   valid bits at once and restores image_size = 512, radius = 1.
// ----------------------------------------------------------------------------
module median_filter_2d #(
    parameter int MAX_SIZE   = 512,
    parameter int MAX_RADIUS = 3,
    parameter int PIXEL_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] pixel
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] median
    output logic       m_axis_tlast,    // row_end
    output logic [0:0] m_axis_tuser,    // [0] frame_end
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);
    import mf_pkg::*;

    localparam int NW    = ($clog2(MAX_SIZE + 1) > 10) ? $clog2(MAX_SIZE + 1) : 10;
    localparam int VB    = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
    localparam int SMAX  = 2 * MAX_RADIUS + 1;
    localparam int SLW   = (SMAX > 1) ? $clog2(SMAX) : 1;
    localparam int QW    = $bits(t_job_ctrl) + SLW + VB * SMAX;
    localparam int QD    = 2;

    // Configuration registers
    logic [9:0] r_image_size;
    logic [1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 10'd512;
            r_radius     <= 2'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_SIZE:   r_image_size <= i_cfg_data;
                CFG_IDX_RADIUS: r_radius     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Effective sizes: size zero acts as one, both saturate at their maxima
    logic [NW-1:0] eff_size;
    logic [3:0]    eff_r, lanes, side;
    logic [7:0]    side_sq;
    logic [5:0]    need;

    assign eff_size = (r_image_size == '0) ? NW'(1) :
                      (NW'(r_image_size) > NW'(MAX_SIZE)) ? NW'(MAX_SIZE) :
                      NW'(r_image_size);
    assign eff_r    = ({2'b00, r_radius} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) :
                      {2'b00, r_radius};
    assign lanes    = {eff_r[2:0], 1'b0};
    assign side     = lanes + 1'b1;
    assign side_sq  = side * side;
    assign need     = 6'((side_sq + 8'd1) >> 1);

    // Front to queue
    logic              f_push, q_room, q_valid, b_pop;
    t_job_ctrl         f_ctrl, q_ctrl;
    logic [SLW-1:0]    f_slot, q_slot;
    logic [VB*SMAX-1:0] f_col, q_col;
    logic [QW-1:0]     q_data;

    mf_front #(
        .MAX_SIZE(MAX_SIZE), .MAX_RADIUS(MAX_RADIUS), .VB(VB), .NW(NW), .SLW(SLW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel   (s_axis_tdata),
        .i_restart (i_cfg_valid),
        .i_size    (eff_size),
        .i_lanes   (lanes),
        .i_side    (side),
        .i_q_room  (q_room),
        .o_push    (f_push),
        .o_ctrl    (f_ctrl),
        .o_slot    (f_slot),
        .o_col     (f_col)
    );

    // Hold up to two jobs so the front can keep accepting while the back searches
    mf_queue #(.WIDTH(QW), .DEPTH(QD)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctrl, f_slot, f_col}),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_room  (q_room),
        .o_data  (q_data)
    );

    assign q_ctrl = t_job_ctrl'(q_data[QW-1 -: $bits(t_job_ctrl)]);
    assign q_slot = q_data[VB*SMAX +: SLW];
    assign q_col  = q_data[VB*SMAX-1:0];

    logic b_frame_end;

    mf_back #(.VB(VB), .SMAX(SMAX), .SLW(SLW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_ctrl      (q_ctrl),
        .i_slot      (q_slot),
        .i_col       (q_col),
        .o_pop       (b_pop),
        .i_side      (side),
        .i_need      (need),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_median    (m_axis_tdata),
        .o_row_end   (m_axis_tlast),
        .o_frame_end (b_frame_end)
    );

    assign m_axis_tuser = b_frame_end;
endmodule
